// ===== hdl/mer_pkg.sv =====
`default_nettype none

package mer_pkg;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_R1   = 2'd1,
        PH_R2   = 2'd2
    } phase_t;

    typedef enum logic [3:0] {
        OP_NONE    = 4'd0,
        OP_LOAD    = 4'd1,
        OP_SQ_A    = 4'd2,
        OP_SQ_B    = 4'd3,
        OP_AY      = 4'd4,
        OP_A2B2    = 4'd5,
        OP_INIT_D  = 4'd6,
        OP_R1_MOVE = 4'd7,
        OP_R1_DEC  = 4'd8,
        OP_SW_M1   = 4'd9,
        OP_SW_M2   = 4'd10,
        OP_SW_D    = 4'd11,
        OP_R2_MOVE = 4'd12,
        OP_R2_DEC  = 4'd13
    } op_t;

    typedef enum logic [1:0] {
        OUT_NONE  = 2'd0,
        OUT_ZERO  = 2'd1,
        OUT_POINT = 2'd2,
        OUT_LAST  = 2'd3
    } out_sel_t;

    typedef struct packed {
        op_t      op;
        out_sel_t out_sel;
    } cmd_t;

    typedef struct packed {
        logic slope_ge;
        logic y_zero;
    } status_t;

endpackage

`default_nettype wire

// ===== hdl/mer_ctrl.sv =====
`default_nettype none

module mer_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              func,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output mer_pkg::cmd_t          cmd,
    input  wire mer_pkg::status_t  status
);

    typedef enum logic [13:0] {
        S_READY     = 14'h0001,
        S_SQA       = 14'h0002,
        S_SQB       = 14'h0004,
        S_AY        = 14'h0008,
        S_A2B2      = 14'h0010,
        S_INITD     = 14'h0020,
        S_IDLE_STEP = 14'h0040,
        S_R1_MOVE   = 14'h0080,
        S_R1_DEC    = 14'h0100,
        S_SW_M1     = 14'h0200,
        S_SW_M2     = 14'h0400,
        S_SW_D      = 14'h0800,
        S_R2_MOVE   = 14'h1000,
        S_R2_DEC    = 14'h2000
    } state_t;

    state_t          state_reg, state_next;
    mer_pkg::phase_t phase_reg, phase_next;
    logic            out_valid_reg, out_valid_next;
    logic            accept;
    logic            out_free;

    assign in_stall  = (state_reg != S_READY);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        cmd.op      = mer_pkg::OP_NONE;
        cmd.out_sel = mer_pkg::OUT_NONE;
        unique case (state_reg)
            S_READY:
            begin
                if (accept)
                begin
                    if (func == mer_pkg::FUNC_START)
                    begin
                        cmd.op     = mer_pkg::OP_LOAD;
                        state_next = S_SQA;
                    end
                    else
                    begin
                        unique case (phase_reg)
                            mer_pkg::PH_R1: state_next = S_R1_MOVE;
                            mer_pkg::PH_R2: state_next = S_R2_MOVE;
                            default:        state_next = S_IDLE_STEP;
                        endcase
                    end
                end
            end
            S_SQA:
            begin
                cmd.op     = mer_pkg::OP_SQ_A;
                state_next = S_SQB;
            end
            S_SQB:
            begin
                cmd.op     = mer_pkg::OP_SQ_B;
                state_next = S_AY;
            end
            S_AY:
            begin
                cmd.op     = mer_pkg::OP_AY;
                state_next = S_A2B2;
            end
            S_A2B2:
            begin
                cmd.op     = mer_pkg::OP_A2B2;
                state_next = S_INITD;
            end
            S_INITD:
            begin
                if (out_free)
                begin
                    cmd.op      = mer_pkg::OP_INIT_D;
                    cmd.out_sel = mer_pkg::OUT_ZERO;
                    phase_next  = mer_pkg::PH_R1;
                    state_next  = S_READY;
                end
            end
            S_IDLE_STEP:
            begin
                if (out_free)
                begin
                    cmd.out_sel = mer_pkg::OUT_ZERO;
                    state_next  = S_READY;
                end
            end
            S_R1_MOVE:
            begin
                // slope crossed: rebuild the decision value for the steep part
                if (status.slope_ge)
                begin
                    phase_next = mer_pkg::PH_R2;
                    state_next = S_SW_M1;
                end
                else if (out_free)
                begin
                    cmd.op      = mer_pkg::OP_R1_MOVE;
                    cmd.out_sel = mer_pkg::OUT_POINT;
                    state_next  = S_R1_DEC;
                end
            end
            S_R1_DEC:
            begin
                cmd.op     = mer_pkg::OP_R1_DEC;
                state_next = S_READY;
            end
            S_SW_M1:
            begin
                cmd.op     = mer_pkg::OP_SW_M1;
                state_next = S_SW_M2;
            end
            S_SW_M2:
            begin
                cmd.op     = mer_pkg::OP_SW_M2;
                state_next = S_SW_D;
            end
            S_SW_D:
            begin
                cmd.op     = mer_pkg::OP_SW_D;
                state_next = S_R2_MOVE;
            end
            S_R2_MOVE:
            begin
                if (out_free)
                begin
                    if (status.y_zero)
                    begin
                        cmd.out_sel = mer_pkg::OUT_LAST;
                        phase_next  = mer_pkg::PH_IDLE;
                        state_next  = S_READY;
                    end
                    else
                    begin
                        cmd.op      = mer_pkg::OP_R2_MOVE;
                        cmd.out_sel = mer_pkg::OUT_POINT;
                        state_next  = S_R2_DEC;
                    end
                end
            end
            S_R2_DEC:
            begin
                cmd.op     = mer_pkg::OP_R2_DEC;
                state_next = S_READY;
            end
            default:
            begin
                state_next = S_READY;
            end
        endcase
    end

    // hold a stalled result, load a new one whenever the datapath emits
    assign out_valid_next = (out_valid_reg && out_stall) || (cmd.out_sel != mer_pkg::OUT_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_READY;
            phase_reg     <= mer_pkg::PH_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/mer_datapath.sv =====
`default_nettype none

module mer_datapath
#(
    parameter int COORD_BITS = 10
)
(
    input  wire logic                         clk,
    input  wire mer_pkg::cmd_t                cmd,
    output mer_pkg::status_t                  status,
    input  wire logic [COORD_BITS-1:0]        center_x,
    input  wire logic [COORD_BITS-1:0]        center_y,
    input  wire logic [COORD_BITS-1:0]        radius_a,
    input  wire logic [COORD_BITS-1:0]        radius_b,
    output logic                              point_valid,
    output logic signed [COORD_BITS+1:0]      px_pos_pos,
    output logic signed [COORD_BITS+1:0]      py_pos_pos,
    output logic signed [COORD_BITS+1:0]      px_neg_pos,
    output logic signed [COORD_BITS+1:0]      py_neg_pos,
    output logic signed [COORD_BITS+1:0]      px_pos_neg,
    output logic signed [COORD_BITS+1:0]      py_pos_neg,
    output logic signed [COORD_BITS+1:0]      px_neg_neg,
    output logic signed [COORD_BITS+1:0]      py_neg_neg,
    output logic                              last_group
);

    localparam int CB = COORD_BITS;
    localparam int OB = COORD_BITS + 2;
    localparam int DW = 4 * COORD_BITS + 6;

    logic [CB-1:0]   cx_reg, cy_reg, a_reg, b_reg, x_reg, y_reg;
    logic [2*CB-1:0] a2_reg, b2_reg;
    logic [3*CB-1:0] bx_reg, ay_reg;
    logic [4*CB-1:0] a2b2_reg, t1_reg, t2_reg;
    logic [DW-1:0]   dec_reg;

    logic [CB-1:0]   x_inc, ym1;
    logic [3*CB-1:0] bx_inc, ay_dec, aym;
    logic            dec_neg, dec_pos;

    logic [3*CB-1:0] mul_a;
    logic [2*CB-1:0] mul_b;
    logic [5*CB-1:0] mul_full;

    logic [DW-1:0]   a2_d, b2_d, bx_d, ay_d, t1_d, t2_d, a2b2_d;
    logic [DW-1:0]   dec_next;

    logic [OB-1:0]   cx_o, cy_o, x_o, y_o;

    logic            pv_reg, last_reg;
    logic [OB-1:0]   xpp_reg, ypp_reg, xnp_reg, ynp_reg;
    logic [OB-1:0]   xpn_reg, ypn_reg, xnn_reg, ynn_reg;

    assign x_inc   = x_reg + 1'b1;
    // b2*x tracks x, including its wrap back to zero
    assign bx_inc  = (&x_reg) ? '0 : bx_reg + (3*CB)'(b2_reg);
    assign ay_dec  = ay_reg - (3*CB)'(a2_reg);
    assign ym1     = (y_reg == '0) ? CB'(1) : y_reg - 1'b1;
    assign aym     = (y_reg == '0) ? (3*CB)'(a2_reg) : ay_dec;
    assign dec_neg = dec_reg[DW-1];
    assign dec_pos = !dec_neg && (dec_reg != '0);

    assign status.slope_ge = (bx_reg >= ay_reg);
    assign status.y_zero   = (y_reg == '0);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            mer_pkg::OP_SQ_A:
            begin
                mul_a = (3*CB)'(a_reg);
                mul_b = (2*CB)'(a_reg);
            end
            mer_pkg::OP_SQ_B:
            begin
                mul_a = (3*CB)'(b_reg);
                mul_b = (2*CB)'(b_reg);
            end
            mer_pkg::OP_AY:
            begin
                mul_a = (3*CB)'(a2_reg);
                mul_b = (2*CB)'(b_reg);
            end
            mer_pkg::OP_A2B2:
            begin
                mul_a = (3*CB)'(a2_reg);
                mul_b = b2_reg;
            end
            mer_pkg::OP_SW_M1:
            begin
                mul_a = bx_reg;
                mul_b = (2*CB)'(x_reg);
            end
            mer_pkg::OP_SW_M2:
            begin
                mul_a = aym;
                mul_b = (2*CB)'(ym1);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    assign a2_d   = DW'(a2_reg);
    assign b2_d   = DW'(b2_reg);
    assign bx_d   = DW'(bx_reg);
    assign ay_d   = DW'(ay_reg);
    assign t1_d   = DW'(t1_reg);
    assign t2_d   = DW'(t2_reg);
    assign a2b2_d = DW'(a2b2_reg);

    always_comb
    begin
        dec_next = dec_reg;
        unique case (cmd.op)
            mer_pkg::OP_INIT_D:
                dec_next = (b2_d << 2) - (ay_d << 2) + a2_d;
            // b2*(2x+1)^2 + 4*a2*(y-1)^2 - 4*a2*b2, with b2*x and a2*(y-1) known
            mer_pkg::OP_SW_D:
                dec_next = (t1_d << 2) + (bx_d << 2) + b2_d + (t2_d << 2) - (a2b2_d << 2);
            mer_pkg::OP_R1_DEC:
                dec_next = dec_reg + (bx_d << 3) + (b2_d << 2)
                           - (dec_neg ? DW'(0) : (ay_d << 3));
            mer_pkg::OP_R2_DEC:
                dec_next = dec_reg + (a2_d << 2) - (ay_d << 3)
                           + (dec_pos ? DW'(0) : (bx_d << 3));
            default:
                dec_next = dec_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        dec_reg <= dec_next;
        unique case (cmd.op)
            mer_pkg::OP_LOAD:
            begin
                cx_reg <= center_x;
                cy_reg <= center_y;
                a_reg  <= radius_a;
                b_reg  <= radius_b;
                x_reg  <= '0;
                y_reg  <= radius_b;
                bx_reg <= '0;
            end
            mer_pkg::OP_SQ_A:  a2_reg   <= mul_full[2*CB-1:0];
            mer_pkg::OP_SQ_B:  b2_reg   <= mul_full[2*CB-1:0];
            mer_pkg::OP_AY:    ay_reg   <= mul_full[3*CB-1:0];
            mer_pkg::OP_A2B2:  a2b2_reg <= mul_full[4*CB-1:0];
            mer_pkg::OP_SW_M1: t1_reg   <= mul_full[4*CB-1:0];
            mer_pkg::OP_SW_M2: t2_reg   <= mul_full[4*CB-1:0];
            mer_pkg::OP_R1_MOVE:
            begin
                x_reg  <= x_inc;
                bx_reg <= bx_inc;
                if (!dec_neg)
                begin
                    y_reg  <= y_reg - 1'b1;
                    ay_reg <= ay_dec;
                end
            end
            mer_pkg::OP_R2_MOVE:
            begin
                y_reg  <= y_reg - 1'b1;
                ay_reg <= ay_dec;
                if (!dec_pos)
                begin
                    x_reg  <= x_inc;
                    bx_reg <= bx_inc;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign cx_o = OB'(cx_reg);
    assign cy_o = OB'(cy_reg);
    assign x_o  = OB'(x_reg);
    assign y_o  = OB'(y_reg);

    always_ff @(posedge clk)
    begin
        case (cmd.out_sel)
            mer_pkg::OUT_ZERO:
            begin
                pv_reg   <= 1'b0;
                last_reg <= 1'b0;
                xpp_reg  <= '0;
                ypp_reg  <= '0;
                xnp_reg  <= '0;
                ynp_reg  <= '0;
                xpn_reg  <= '0;
                ypn_reg  <= '0;
                xnn_reg  <= '0;
                ynn_reg  <= '0;
            end
            mer_pkg::OUT_POINT, mer_pkg::OUT_LAST:
            begin
                pv_reg   <= 1'b1;
                last_reg <= (cmd.out_sel == mer_pkg::OUT_LAST);
                xpp_reg  <= cx_o + x_o;
                ypp_reg  <= cy_o + y_o;
                xnp_reg  <= cx_o - x_o;
                ynp_reg  <= cy_o + y_o;
                xpn_reg  <= cx_o + x_o;
                ypn_reg  <= cy_o - y_o;
                xnn_reg  <= cx_o - x_o;
                ynn_reg  <= cy_o - y_o;
            end
            default:
            begin
            end
        endcase
    end

    assign point_valid = pv_reg;
    assign last_group  = last_reg;
    assign px_pos_pos  = $signed(xpp_reg);
    assign py_pos_pos  = $signed(ypp_reg);
    assign px_neg_pos  = $signed(xnp_reg);
    assign py_neg_pos  = $signed(ynp_reg);
    assign px_pos_neg  = $signed(xpn_reg);
    assign py_pos_neg  = $signed(ypn_reg);
    assign px_neg_neg  = $signed(xnn_reg);
    assign py_neg_neg  = $signed(ynn_reg);

endmodule

`default_nettype wire

// ===== hdl/midpoint_ellipse_rasterizer_unit.sv =====
`default_nettype none

// channel  | direction | handshake           | payload
// ---------+-----------+---------------------+----------------------------------------
// in       | input     | in_valid / in_stall | func, center_x, center_y, radius_a/b
// out      | output    | out_valid/out_stall | point_valid, px_*/py_* (x4), last_group
//
// Start: accept, then a*a, b*b, a2*b and a2*b2 on one multiplier, then the decision value.
// Step: accept, emit and move, decision update; last group or none loaded: accept and emit.
// Region switch step: slope test, two more multiplier passes, decision rebuild, then the
// region-2 emit and update; no update when that emit is the last group.
// Reset clears the controller and the output valid only; no clearing pass.
// A stalled result holds in the output register; the next emit waits for its transfer.

module midpoint_ellipse_rasterizer_unit
#(
    parameter int COORD_BITS = 10
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic                     func,
    input  wire logic [COORD_BITS-1:0]    center_x,
    input  wire logic [COORD_BITS-1:0]    center_y,
    input  wire logic [COORD_BITS-1:0]    radius_a,
    input  wire logic [COORD_BITS-1:0]    radius_b,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic                          point_valid,
    output logic signed [COORD_BITS+1:0]  px_pos_pos,
    output logic signed [COORD_BITS+1:0]  py_pos_pos,
    output logic signed [COORD_BITS+1:0]  px_neg_pos,
    output logic signed [COORD_BITS+1:0]  py_neg_pos,
    output logic signed [COORD_BITS+1:0]  px_pos_neg,
    output logic signed [COORD_BITS+1:0]  py_pos_neg,
    output logic signed [COORD_BITS+1:0]  px_neg_neg,
    output logic signed [COORD_BITS+1:0]  py_neg_neg,
    output logic                          last_group
);

    mer_pkg::cmd_t    cmd;
    mer_pkg::status_t status;

    mer_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    mer_datapath #(.COORD_BITS(COORD_BITS)) u_datapath
    (
        .clk         (clk),
        .cmd         (cmd),
        .status      (status),
        .center_x    (center_x),
        .center_y    (center_y),
        .radius_a    (radius_a),
        .radius_b    (radius_b),
        .point_valid (point_valid),
        .px_pos_pos  (px_pos_pos),
        .py_pos_pos  (py_pos_pos),
        .px_neg_pos  (px_neg_pos),
        .py_neg_pos  (py_neg_pos),
        .px_pos_neg  (px_pos_neg),
        .py_pos_neg  (py_pos_neg),
        .px_neg_neg  (px_neg_neg),
        .py_neg_neg  (py_neg_neg),
        .last_group  (last_group)
    );

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && func == mer_pkg::FUNC_START) |=> in_stall)
        else $error("start transfer did not occupy the block");

    a_last_is_point: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_group) |-> point_valid)
        else $error("last group flagged on a result without points");

    a_symmetry: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && point_valid) |->
            (px_pos_pos == px_pos_neg && px_neg_pos == px_neg_neg &&
             py_pos_pos == py_neg_pos && py_pos_neg == py_neg_neg))
        else $error("point group is not symmetric about the center");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !point_valid) |-> (px_pos_pos == 0 && py_pos_neg == 0 && !last_group))
        else $error("empty result carries nonzero fields");

endmodule

`default_nettype wire

// ===== test/ellipse_point_checker.sv =====
module ellipse_point_checker
#(
    parameter int COORD_BITS = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic                  func,
    input  logic [COORD_BITS-1:0] center_x,
    input  logic [COORD_BITS-1:0] center_y,
    input  logic [COORD_BITS-1:0] radius_a,
    input  logic [COORD_BITS-1:0] radius_b,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic                  point_valid,
    input  logic [COORD_BITS+1:0] px_pos_pos,
    input  logic [COORD_BITS+1:0] py_pos_pos,
    input  logic [COORD_BITS+1:0] px_neg_pos,
    input  logic [COORD_BITS+1:0] py_neg_pos,
    input  logic [COORD_BITS+1:0] px_pos_neg,
    input  logic [COORD_BITS+1:0] py_pos_neg,
    input  logic [COORD_BITS+1:0] px_neg_neg,
    input  logic [COORD_BITS+1:0] py_neg_neg,
    input  logic                  last_group,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OW = COORD_BITS + 2;
    localparam logic [63:0] COORD_MASK = (64'd1 << COORD_BITS) - 64'd1;

    // corner order: (+x,+y), (-x,+y), (+x,-y), (-x,-y)
    typedef struct packed {
        logic               valid;
        logic [3:0][OW-1:0] px;
        logic [3:0][OW-1:0] py;
        logic               last;
    } point_group_t;

    string corner_tag [4] = '{"pos_pos", "neg_pos", "pos_neg", "neg_neg"};

    point_group_t expected_groups [$];

    mer_pkg::phase_t walk;
    logic [63:0]     pos_x;
    logic [63:0]     pos_y;
    logic [63:0]     err_term;
    logic [63:0]     ax_sq;
    logic [63:0]     by_sq;
    logic [63:0]     org_x;
    logic [63:0]     org_y;

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    function automatic point_group_t mirror_points(input logic [63:0] x,
                                                   input logic [63:0] y,
                                                   input logic last);
        point_group_t g;
        logic [63:0]  xp;
        logic [63:0]  xn;
        logic [63:0]  yp;
        logic [63:0]  yn;
        xp = org_x + x;
        xn = org_x - x;
        yp = org_y + y;
        yn = org_y - y;
        g.valid = 1'b1;
        g.px[0] = xp[OW-1:0];
        g.py[0] = yp[OW-1:0];
        g.px[1] = xn[OW-1:0];
        g.py[1] = yp[OW-1:0];
        g.px[2] = xp[OW-1:0];
        g.py[2] = yn[OW-1:0];
        g.px[3] = xn[OW-1:0];
        g.py[3] = yn[OW-1:0];
        g.last = last;
        return g;
    endfunction

    // steep part: drop y until it is zero, advance x when the midpoint lies inside
    function automatic void descend_region2(output point_group_t g);
        logic [63:0] y1;
        logic [63:0] x1;
        if (pos_y == 64'd0)
        begin
            g = mirror_points(pos_x, pos_y, 1'b1);
            walk = mer_pkg::PH_IDLE;
        end
        else
        begin
            g = mirror_points(pos_x, pos_y, 1'b0);
            y1 = pos_y - 64'd1;
            if (!err_term[63] && err_term != 64'd0)
            begin
                err_term = err_term + 64'd4 * ax_sq - 64'd8 * ax_sq * y1;
            end
            else
            begin
                x1 = (pos_x + 64'd1) & COORD_MASK;
                err_term = err_term + 64'd8 * by_sq * x1 - 64'd8 * ax_sq * y1
                           + 64'd4 * ax_sq;
                pos_x = x1;
            end
            pos_y = y1;
        end
    endfunction

    function automatic point_group_t next_point_group(input logic f,
                                                      input logic [COORD_BITS-1:0] cx,
                                                      input logic [COORD_BITS-1:0] cy,
                                                      input logic [COORD_BITS-1:0] ra,
                                                      input logic [COORD_BITS-1:0] rb);
        point_group_t g;
        logic [63:0]  a;
        logic [63:0]  b;
        logic [63:0]  t;
        logic [63:0]  ym1;
        logic [63:0]  x1;
        logic [63:0]  y1;
        g = '0;
        if (f == mer_pkg::FUNC_START)
        begin
            a = {{(64-COORD_BITS){1'b0}}, ra};
            b = {{(64-COORD_BITS){1'b0}}, rb};
            org_x = {{(64-COORD_BITS){1'b0}}, cx};
            org_y = {{(64-COORD_BITS){1'b0}}, cy};
            ax_sq = a * a;
            by_sq = b * b;
            pos_x = 64'd0;
            pos_y = b;
            err_term = 64'd4 * by_sq - 64'd4 * ax_sq * b + ax_sq;
            walk = mer_pkg::PH_R1;
        end
        else if (walk == mer_pkg::PH_R1)
        begin
            if (by_sq * pos_x >= ax_sq * pos_y)
            begin
                // slope reached -1: rebuild the decision from the current point
                t = 64'd2 * pos_x + 64'd1;
                ym1 = (pos_y == 64'd0) ? 64'd1 : pos_y - 64'd1;
                err_term = by_sq * t * t + 64'd4 * ax_sq * ym1 * ym1
                           - 64'd4 * ax_sq * by_sq;
                walk = mer_pkg::PH_R2;
                descend_region2(g);
            end
            else
            begin
                g = mirror_points(pos_x, pos_y, 1'b0);
                x1 = (pos_x + 64'd1) & COORD_MASK;
                if (err_term[63])
                begin
                    err_term = err_term + 64'd8 * by_sq * x1 + 64'd4 * by_sq;
                end
                else
                begin
                    y1 = (pos_y - 64'd1) & COORD_MASK;
                    err_term = err_term + 64'd8 * by_sq * x1 - 64'd8 * ax_sq * y1
                               + 64'd4 * by_sq;
                    pos_y = y1;
                end
                pos_x = x1;
            end
        end
        else if (walk == mer_pkg::PH_R2)
        begin
            descend_region2(g);
        end
        return g;
    endfunction

    task automatic note_mismatch(input string field, input logic [OW-1:0] want,
                                 input logic [OW-1:0] got);
        fail_count++;
        $display("%0t ns: %s expected 0x%03h, got 0x%03h", $time, field, want, got);
    endtask

    task automatic check_group(input point_group_t want, input point_group_t got);
        if (got.valid !== want.valid)
        begin
            note_mismatch("point_valid", {{(OW-1){1'b0}}, want.valid},
                          {{(OW-1){1'b0}}, got.valid});
        end
        for (int k = 0; k < 4; k++)
        begin
            if (got.px[k] !== want.px[k])
            begin
                note_mismatch({"px_", corner_tag[k]}, want.px[k], got.px[k]);
            end
            if (got.py[k] !== want.py[k])
            begin
                note_mismatch({"py_", corner_tag[k]}, want.py[k], got.py[k]);
            end
        end
        if (got.last !== want.last)
        begin
            note_mismatch("last_group", {{(OW-1){1'b0}}, want.last},
                          {{(OW-1){1'b0}}, got.last});
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        point_group_t got;
        if (!rst_n)
        begin
            walk = mer_pkg::PH_IDLE;
            pos_x = '0;
            pos_y = '0;
            err_term = '0;
            ax_sq = '0;
            by_sq = '0;
            org_x = '0;
            org_y = '0;
            expected_groups.delete();
        end
        else
        begin
            // check the result before queuing this edge's transfer
            if (out_valid && !out_stall)
            begin
                got.valid = point_valid;
                got.px[0] = px_pos_pos;
                got.py[0] = py_pos_pos;
                got.px[1] = px_neg_pos;
                got.py[1] = py_neg_pos;
                got.px[2] = px_pos_neg;
                got.py[2] = py_pos_neg;
                got.px[3] = px_neg_neg;
                got.py[3] = py_neg_neg;
                got.last = last_group;
                if (expected_groups.size() == 0)
                begin
                    fail_count++;
                    $display("%0t ns: result transfer with none expected, got %h",
                             $time, got);
                end
                else
                begin
                    check_group(expected_groups.pop_front(), got);
                end
            end
            if (in_valid && !in_stall)
            begin
                expected_groups.push_back(next_point_group(func, center_x, center_y,
                                                           radius_a, radius_b));
            end
        end
        pending = expected_groups.size();
    end

endmodule

// ===== test/midpoint_ellipse_rasterizer_unit_test.sv =====
module midpoint_ellipse_rasterizer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW           = 10;
    localparam int RANDOM_ITEMS = 700;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 16;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_BLOCKS
    } stall_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  func;
    logic [CW-1:0]         center_x;
    logic [CW-1:0]         center_y;
    logic [CW-1:0]         radius_a;
    logic [CW-1:0]         radius_b;
    logic                  out_valid;
    logic                  out_stall;
    logic                  point_valid;
    logic signed [CW+1:0]  px_pos_pos;
    logic signed [CW+1:0]  py_pos_pos;
    logic signed [CW+1:0]  px_neg_pos;
    logic signed [CW+1:0]  py_neg_pos;
    logic signed [CW+1:0]  px_pos_neg;
    logic signed [CW+1:0]  py_pos_neg;
    logic signed [CW+1:0]  px_neg_neg;
    logic signed [CW+1:0]  py_neg_neg;
    logic                  last_group;
    int                    fail_count;
    int                    pending;

    logic in_taken = 1'b0;
    int   burst_left = 0;
    int   items_sent = 0;

    midpoint_ellipse_rasterizer_unit #(.COORD_BITS(CW)) DUT (.*);

    ellipse_point_checker #(.COORD_BITS(CW)) point_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        in_taken <= in_valid && !in_stall;
    end

    function automatic logic [CW-1:0] rand_coord();
        logic [31:0] r;
        r = $urandom;
        return r[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] rand_upto(input int hi);
        logic [31:0] r;
        r = $urandom_range(0, hi);
        return r[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] pick_center();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
        begin
            return '0;
        end
        else if (sel == 1)
        begin
            return '1;
        end
        return rand_coord();
    endfunction

    // hold the payload until the transfer, then maybe close the burst
    task automatic send(input logic f, input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                        input logic [CW-1:0] ra, input logic [CW-1:0] rb);
        int gap;
        in_valid <= 1'b1;
        func <= f;
        center_x <= cx;
        center_y <= cy;
        radius_a <= ra;
        radius_b <= rb;
        do @(negedge clk); while (!in_taken);
        items_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 10);
        end
    endtask

    task automatic run_ellipse(input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                               input logic [CW-1:0] ra, input logic [CW-1:0] rb,
                               input int steps);
        send(mer_pkg::FUNC_START, cx, cy, ra, rb);
        repeat (steps)
        begin
            send(mer_pkg::FUNC_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord());
        end
    endtask

    initial
    begin : stall_pattern
        stall_mode_t mode;
        int          span;
        int          block_len;
        out_stall = 1'b0;
        forever
        begin
            mode = stall_mode_t'($urandom_range(0, 3));
            span = $urandom_range(20, 150);
            block_len = $urandom_range(1, 6);
            for (int c = 0; c < span; c++)
            begin
                @(negedge clk);
                case (mode)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                    default:     out_stall <= ((c / block_len) % 2 == 1);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        int            kind;
        int            steps;
        logic [CW-1:0] ra;
        logic [CW-1:0] rb;
        logic [CW-1:0] noise;
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = mer_pkg::FUNC_STEP;
        center_x = '0;
        center_y = '0;
        radius_a = '0;
        radius_b = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // step with nothing loaded
        send(mer_pkg::FUNC_STEP, '1, '1, '1, '1);
        // zero horizontal axis at the origin, negative corners wrap
        run_ellipse('0, '0, '0, 10'd2, 4);
        // zero vertical axis: one last group, then an idle step
        run_ellipse('1, '1, 10'd3, '0, 2);
        run_ellipse('0, '1, '0, '0, 1);
        // largest axes, cut short by the next start
        run_ellipse('1, '0, '1, '1, 5);
        run_ellipse(10'd512, 10'd512, 10'd2, 10'd5, 8);

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 3)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    noise = rand_coord();
                    send(noise[0], rand_coord(), rand_coord(), rand_coord(), rand_coord());
                end
            end
            else
            begin
                if (kind == 3)
                begin
                    ra = rand_coord();
                    rb = rand_coord();
                    steps = $urandom_range(5, 40);
                end
                else if (kind == 4)
                begin
                    ra = rand_upto(40);
                    rb = rand_upto(40);
                    steps = ra + rb + 1;
                end
                else
                begin
                    ra = rand_upto(12);
                    rb = rand_upto(12);
                    steps = ra + rb + 1 + $urandom_range(0, 1);
                end
                run_ellipse(pick_center(), pick_center(), ra, rb, steps);
            end
        end
        in_valid <= 1'b0;

        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
